FILE: hdl/dmkv_pkg.sv
// shared constants, types and codes for the direct mapped key value table
package dmkv_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_W     = 32;
	localparam int KEY_W       = 64;
	localparam int COUNT_W     = 11;
	localparam int BUCKET_W    = $clog2(TABLE_DEPTH);
	localparam int SUM_W       = $clog2(KEY_BYTES * 255 + 1);

	typedef enum logic [1:0] {
		REQ_PUT    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP
	} fsm_state_t;

	// what one byte lane hands to the merge
	typedef struct packed {
		logic       alive;
		logic [7:0] kept;
	} lane_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [BUCKET_W-1:0] bucket;
	} hash_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/dmkv_if.sv
// request and response channel interfaces
interface dmkv_req_if;
	import dmkv_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

interface dmkv_rsp_if;
	import dmkv_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [VALUE_W-1:0] found_value;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, output status, output found_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input found_value, input entry_count,
		output ready);
endinterface

FILE: hdl/direct_mapped_key_value_table.sv
// top level: direct mapped key value table with additive hash
//
//   channel | dir | fields                              | handshake
//   req     | in  | req_type, key, value                | valid / ready
//   rsp     | out | status, found_value, entry_count    | valid / ready
//
// each item passes through idle and lookup: the bucket is read from the entry
// ram on acceptance, then lookup decides and writes back through the same ram.
// after reset a clearing pass over all 1024 buckets wipes the valid marks;
// req.ready stays low until it ends. a result waits in the output register;
// while it is not taken the next item may be accepted but holds in lookup.
module direct_mapped_key_value_table (
	input  logic        clk,
	input  logic        arst_n,
	dmkv_req_if.sink    req,
	dmkv_rsp_if.source  rsp
);
	import dmkv_pkg::*;

	localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(TABLE_DEPTH - 1);
	localparam logic [COUNT_W-1:0]  FULL_COUNT  = COUNT_W'(TABLE_DEPTH);

	fsm_state_t state_q, state_d;

	logic [BUCKET_W-1:0] clr_addr_q;
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  found_q;

	logic [1:0]          req_type_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic [BUCKET_W-1:0] bucket_s1;

	hash_t hash;

	dmkv_hash u_hash (
		.key  (req.key),
		.hash (hash)
	);

	logic                ram_we;
	logic [BUCKET_W-1:0] ram_waddr;
	entry_t              ram_wdata;
	logic [BUCKET_W-1:0] ram_raddr;
	entry_t              ram_rdata;

	dmkv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic               accept;
	logic               commit;
	logic               hit;
	status_t            status_d;
	logic [VALUE_W-1:0] found_d;
	logic [COUNT_W-1:0] count_d;

	assign accept = req.valid && req.ready;
	assign hit    = ram_rdata.valid && (ram_rdata.key == key_s1);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = bucket_s1;
		ram_wdata = ram_rdata;
		ram_raddr = bucket_s1;
		status_d  = ST_MISS;
		found_d   = '0;
		count_d   = count_q;

		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == LAST_BUCKET) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = hash.bucket;
				if (req.valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				commit = !out_valid_q || rsp.ready;
				case (req_type_s1)
					REQ_PUT: begin
						if (count_q == FULL_COUNT) begin
							status_d = ST_FULL;
						end else if (ram_rdata.valid) begin
							status_d = ST_MISS;
						end else begin
							status_d        = ST_OK;
							ram_we          = commit;
							ram_wdata.valid = 1'b1;
							ram_wdata.key   = key_s1;
							ram_wdata.value = value_s1;
							count_d         = count_q + 1'b1;
						end
					end
					REQ_REMOVE: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else if (hit) begin
							status_d        = ST_OK;
							ram_we          = commit;
							ram_wdata.valid = 1'b0;
							count_d         = count_q - 1'b1;
						end
					end
					REQ_SEARCH: begin
						if (hit) begin
							status_d = ST_OK;
							found_d  = ram_rdata.value;
						end
					end
					default: begin
						status_d = ST_MISS;
					end
				endcase
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the item in flight and of the waiting result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			key_s1      <= hash.key;
			value_s1    <= req.value;
			bucket_s1   <= hash.bucket;
		end
		if (commit) begin
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_value = found_q;
	assign rsp.entry_count = count_q;
endmodule

FILE: hdl/dmkv_ram.sv
// generic single write port ram with registered read
module dmkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/dmkv_byte_lane.sv
// one key byte: keeps it while no terminator has been seen before it
module dmkv_byte_lane (
	input  logic           alive_in,
	input  logic [7:0]     key_byte,
	output dmkv_pkg::lane_t lane
);
	import dmkv_pkg::*;

	always_comb begin
		lane.alive = alive_in && (key_byte != 8'd0);
		lane.kept  = lane.alive ? key_byte : 8'd0;
	end
endmodule

FILE: hdl/dmkv_hash.sv
// byte lanes plus merge: normalised key and additive bucket
module dmkv_hash (
	input  logic [dmkv_pkg::KEY_W-1:0] key,
	output dmkv_pkg::hash_t            hash
);
	import dmkv_pkg::*;

	lane_t lanes [KEY_BYTES];

	for (genvar i = 0; i < KEY_BYTES; i++) begin : g_lane
		if (i == 0) begin : g_first
			dmkv_byte_lane u_lane (
				.alive_in (1'b1),
				.key_byte (key[8*i +: 8]),
				.lane     (lanes[i])
			);
		end else begin : g_next
			dmkv_byte_lane u_lane (
				.alive_in (lanes[i-1].alive),
				.key_byte (key[8*i +: 8]),
				.lane     (lanes[i])
			);
		end
	end

	logic [SUM_W-1:0] sum;
	logic [KEY_W-1:0] norm;

	always_comb begin
		sum  = '0;
		norm = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			sum            = sum + SUM_W'(lanes[i].kept);
			norm[8*i +: 8] = lanes[i].kept;
		end
		hash.key    = norm;
		hash.bucket = BUCKET_W'(sum % TABLE_DEPTH);
	end
endmodule

FILE: tb/direct_mapped_key_value_table_test.sv
// testbench for the direct mapped key value table: directed rows, random traffic, shadow table
`timescale 1ns / 100ps

module direct_mapped_key_value_table_test;
	import dmkv_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int IDLE_PCT    = 32;
	localparam int N_DIRECTED  = 25;
	localparam int MIXED_N     = 150;
	localparam int FULL_N      = 70;
	localparam int POOL_N      = 16;
	localparam int HOT_N       = 6;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM   = 700;
	localparam int CALM_TO     = 900;
	localparam int STALL_LIMIT = 6000;
	localparam int END_WAIT    = 8;

	typedef struct {
		status_t            status;
		logic [VALUE_W-1:0] found;
		logic [COUNT_W-1:0] count;
	} reply_t;

	typedef struct {
		logic [1:0]         req_type;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		bit                 typed;
		reply_t             want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dmkv_req_if req_if();
	dmkv_rsp_if rsp_if();

	direct_mapped_key_value_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow of the table
	bit                 tbl_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
	logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
	int                 n_entries = 0;

	reply_t      replies_due [$];
	int unsigned accepted_n = 0;
	int unsigned errors = 0;

	dir_row_t dir_rows [N_DIRECTED] = '{
		'{REQ_REMOVE, 64'h41, 32'h0, 1'b1, '{ST_EMPTY, 32'h0, 11'd0}},
		'{REQ_SEARCH, 64'h41, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd0}},
		'{REQ_UNUSED, 64'h0, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd0}},
		'{REQ_PUT, 64'h0, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 11'd1}},
		// empty key with junk above the terminator
		'{REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 11'd1}},
		'{REQ_PUT, 64'h41, 32'h0, 1'b1, '{ST_OK, 32'h0, 11'd2}},
		'{REQ_PUT, 64'h41, 32'h5, 1'b1, '{ST_MISS, 32'h0, 11'd2}},
		// same bucket as 0x41, other key
		'{REQ_PUT, 64'h2021, 32'h7, 1'b1, '{ST_MISS, 32'h0, 11'd2}},
		'{REQ_SEARCH, 64'h2021, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd2}},
		'{REQ_REMOVE, 64'h2021, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd2}},
		'{REQ_SEARCH, 64'hDEAD_BEEF_0000_0041, 32'h0, 1'b1, '{ST_OK, 32'h0, 11'd2}},
		'{REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 1'b1, '{ST_OK, 32'h0, 11'd3}},
		'{REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1,
			'{ST_OK, 32'hA5A5_5A5A, 11'd3}},
		'{REQ_PUT, 64'h0101_0101_0101_0101, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 11'd4}},
		'{REQ_REMOVE, 64'h41, 32'h0, 1'b1, '{ST_OK, 32'h0, 11'd3}},
		'{REQ_REMOVE, 64'h41, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd3}},
		'{REQ_SEARCH, 64'h41, 32'h0, 1'b1, '{ST_MISS, 32'h0, 11'd3}},
		'{REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_MISS, 32'h0, 11'd3}},
		'{REQ_SEARCH, 64'h0101_0101_0101_0101, 32'h0, 1'b1,
			'{ST_OK, 32'h8000_0000, 11'd3}},
		'{REQ_REMOVE, 64'h5500, 32'h0, 1'b1, '{ST_OK, 32'h0, 11'd2}},
		// lands in the bucket of the all-ones key, whose byte sum wraps
		'{REQ_PUT, 64'h7F7F_7F7F_7F7F_7F7F, 32'h1, 1'b1, '{ST_MISS, 32'h0, 11'd2}},
		'{REQ_PUT, 64'h0102_0304_0506_0708, 32'h1234_5678, 1'b0, '{ST_OK, 32'h0, 11'd0}},
		'{REQ_SEARCH, 64'h0102_0304_0506_0708, 32'h0, 1'b0, '{ST_OK, 32'h0, 11'd0}},
		'{REQ_PUT, 64'h00FF_00FF_0000_0080, 32'h0F0F_F0F0, 1'b0, '{ST_OK, 32'h0, 11'd0}},
		'{REQ_SEARCH, 64'h80, 32'h0, 1'b0, '{ST_OK, 32'h0, 11'd0}}
	};

	function automatic void hash_key(input logic [KEY_W-1:0] raw,
		output logic [KEY_W-1:0] kept, output int bucket);
		int sum;
		bit ended;
		kept = '0;
		sum = 0;
		ended = 0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00)
				ended = 1;
			if (!ended) begin
				kept[8*i +: 8] = raw[8*i +: 8];
				sum += raw[8*i +: 8];
			end
		end
		bucket = sum % TABLE_DEPTH;
	endfunction

	function automatic reply_t apply_request(input logic [1:0] rt, input logic [KEY_W-1:0] raw,
		input logic [VALUE_W-1:0] v);
		reply_t r;
		logic [KEY_W-1:0] k;
		int b;
		bit hit;
		hash_key(raw, k, b);
		hit = tbl_valid[b] && tbl_key[b] == k;
		r.status = ST_MISS;
		r.found = '0;
		case (rt)
			REQ_PUT: begin
				// full takes precedence over a used bucket
				if (n_entries == TABLE_DEPTH)
					r.status = ST_FULL;
				else if (!tbl_valid[b]) begin
					tbl_valid[b] = 1;
					tbl_key[b] = k;
					tbl_value[b] = v;
					n_entries++;
					r.status = ST_OK;
				end
			end
			REQ_REMOVE: begin
				if (n_entries == 0)
					r.status = ST_EMPTY;
				else if (hit) begin
					tbl_valid[b] = 0;
					n_entries--;
					r.status = ST_OK;
				end
			end
			REQ_SEARCH: begin
				if (hit) begin
					r.status = ST_OK;
					r.found = tbl_value[b];
				end
			end
			default: ;
		endcase
		r.count = n_entries[COUNT_W-1:0];
		return r;
	endfunction

	// fill every byte above the terminator with junk
	function automatic logic [KEY_W-1:0] vary_tail(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		bit ended;
		r = k;
		ended = 0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (ended)
				r[8*i +: 8] = 8'($urandom_range(0, 255));
			else if (k[8*i +: 8] == 8'h00)
				ended = 1;
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] key_for_bucket(input int bucket);
		logic [KEY_W-1:0] k;
		int target, n, rest, lo, hi, add;
		k = '0;
		target = bucket;
		if (target + TABLE_DEPTH <= KEY_BYTES * 255 && $urandom_range(0, 1) == 1)
			target += TABLE_DEPTH;
		if (target == 0)
			return vary_tail(k);
		lo = (target + 254) / 255;
		hi = (target < KEY_BYTES) ? target : KEY_BYTES;
		n = $urandom_range(hi, lo);
		rest = target - n;
		// spread the byte sum so the later bytes can still absorb what is left
		for (int i = 0; i < n; i++) begin
			lo = rest - 254 * (n - 1 - i);
			if (lo < 0)
				lo = 0;
			hi = (rest < 254) ? rest : 254;
			add = $urandom_range(hi, lo);
			k[8*i +: 8] = 8'(1 + add);
			rest -= add;
		end
		return vary_tail(k);
	endfunction

	function automatic logic [KEY_W-1:0] stored_or_fresh(input int bucket);
		return tbl_valid[bucket] ? vary_tail(tbl_key[bucket]) : key_for_bucket(bucket);
	endfunction

	function automatic logic [VALUE_W-1:0] any_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return '0;
		if (pick < 20)
			return '1;
		return $urandom;
	endfunction

	function automatic bit in_calm_stretch();
		return accepted_n >= CALM_FROM && accepted_n < CALM_TO;
	endfunction

	task automatic offer(input logic [1:0] rt, input logic [KEY_W-1:0] k,
		input logic [VALUE_W-1:0] v, input bit typed, input reply_t want);
		reply_t predicted;
		while (!in_calm_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.req_type <= rt;
		req_if.key      <= k;
		req_if.value    <= v;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		accepted_n++;
		predicted = apply_request(rt, k, v);
		replies_due.push_back(typed ? want : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : stimulus
		reply_t none;
		int b, pick;
		logic [1:0] rt;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] key_pool [POOL_N];
		int hot [HOT_N];
		none = '{ST_OK, '0, '0};
		arst_n          <= 1'b0;
		req_if.valid    <= 1'b0;
		req_if.req_type <= REQ_PUT;
		req_if.key      <= '0;
		req_if.value    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i].req_type, dir_rows[i].key, dir_rows[i].value,
				dir_rows[i].typed, dir_rows[i].want);

		// a few hot buckets so that hits and collisions are common
		foreach (hot[i])
			hot[i] = $urandom_range(0, TABLE_DEPTH - 1);
		foreach (key_pool[i])
			key_pool[i] = key_for_bucket(hot[$urandom_range(0, HOT_N - 1)]);
		repeat (MIXED_N) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				rt = REQ_PUT;
			else if (pick < 60)
				rt = REQ_REMOVE;
			else if (pick < 95)
				rt = REQ_SEARCH;
			else
				rt = REQ_UNUSED;
			if ($urandom_range(0, 99) < 80)
				k = vary_tail(key_pool[$urandom_range(0, POOL_N - 1)]);
			else
				k = {$urandom, $urandom};
			offer(rt, k, any_value(), 1'b0, none);
		end

		// fill the table, with some searches and refused puts mixed in
		while (n_entries < TABLE_DEPTH) begin
			b = $urandom_range(0, TABLE_DEPTH - 1);
			if ($urandom_range(0, 99) < 10) begin
				rt = ($urandom_range(0, 1) == 1) ? REQ_SEARCH : REQ_PUT;
				offer(rt, stored_or_fresh(b), any_value(), 1'b0, none);
			end else begin
				while (tbl_valid[b])
					b = (b + 1) % TABLE_DEPTH;
				offer(REQ_PUT, key_for_bucket(b), any_value(), 1'b0, none);
			end
		end

		// around full: refused puts, removes that free a bucket, refills, searches and unused types
		repeat (FULL_N) begin
			b = $urandom_range(0, TABLE_DEPTH - 1);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				rt = REQ_REMOVE;
			else if (pick < 45)
				rt = REQ_SEARCH;
			else if (pick < 55)
				rt = REQ_UNUSED;
			else
				rt = REQ_PUT;
			if (rt == REQ_PUT && n_entries < TABLE_DEPTH)
				while (tbl_valid[b])
					b = (b + 1) % TABLE_DEPTH;
			offer(rt, stored_or_fresh(b), any_value(), 1'b0, none);
		end
		req_if.valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (errors == 0)
			$display("direct_mapped_key_value_table_test: done, clean");
		else
			$display("direct_mapped_key_value_table_test: done, errors");
		$finish;
	end

	initial begin : result_check
		reply_t want;
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected item: expected none, got status %0d", $time,
						rsp_if.status);
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (rsp_if.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status,
							rsp_if.status);
						errors++;
					end
					if (rsp_if.found_value !== want.found) begin
						$display("%0t: found_value expected %h got %h", $time, want.found,
							rsp_if.found_value);
						errors++;
					end
					if (rsp_if.entry_count !== want.count) begin
						$display("%0t: entry_count expected %0d got %0d", $time, want.count,
							rsp_if.entry_count);
						errors++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!held && accepted_n >= HOLD_AT) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else
				rsp_if.ready <= in_calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
				(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("direct_mapped_key_value_table_test: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/dmkv_pkg.sv
hdl/dmkv_if.sv
hdl/dmkv_ram.sv
hdl/dmkv_byte_lane.sv
hdl/dmkv_hash.sv
hdl/direct_mapped_key_value_table.sv
tb/direct_mapped_key_value_table_test.sv
